### rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants of the bounce slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

	localparam int NUM_SLOTS_DEF  = 1024;
	localparam int SLOT_SHIFT_DEF = 11;

	localparam int SIZE_W = 22;
	localparam int ADDR_W = 64;

	localparam logic [2:0] PAGE_SHIFT_RST = 3'd3;

	typedef enum logic [0:0] {
		REG_POOL_BASE  = 1'b0,
		REG_PAGE_SHIFT = 1'b1
	} bsa_reg_t;

	typedef enum logic [0:0] {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} bsa_action_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_NOSPACE = 2'd1,
		STS_ZERO    = 2'd2
	} bsa_status_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_A_RND,
		S_A_RD,
		S_A_CMP,
		S_A_ZERO,
		S_F_END,
		S_F_CNT,
		S_F_FILL,
		S_RN_RD,
		S_RN_CHK,
		S_DONE
	} bsa_state_t;

endpackage

### rtl/bsa_if.sv
// ----------------------------------------------------------------------------
// bsa_if
// Request, response and register write channels of the bounce slot allocator.
// ----------------------------------------------------------------------------
interface bsa_req_if import bsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              action;
	logic [SIZE_W-1:0] size_bytes;
	logic [ADDR_W-1:0] buffer_addr;
	logic [ADDR_W-1:0] bounce_addr_in;

	modport source (output valid, action, size_bytes, buffer_addr, bounce_addr_in,
		input ready);
	modport sink (input valid, action, size_bytes, buffer_addr, bounce_addr_in,
		output ready);
endinterface

interface bsa_rsp_if import bsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [ADDR_W-1:0] bounce_addr_out;
	logic [ADDR_W-1:0] orig_addr;

	modport source (output valid, status, bounce_addr_out, orig_addr, input ready);
	modport sink (input valid, status, bounce_addr_out, orig_addr, output ready);
endinterface

interface bsa_cfg_if import bsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              addr;
	logic [ADDR_W-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

### rtl/bounce_slot_allocator.sv
// ----------------------------------------------------------------------------
// bounce_slot_allocator
// Contiguous run allocator over a pool of bounce slots.
// ----------------------------------------------------------------------------
// One request at a time, walked over a run table with one read port and one
// write port. After reset an initialising pass writes each slot's free run
// length into the table before the first request is taken. Every request
// passes through accept and the result stage. Allocate rounds the cursor up
// to a multiple of the stride to align the start, probes one slot per stride,
// claims the n slots, renumbers the free slots before the run and stops. Free
// finds the end of the region, rebuilds it, merges the free slots before it
// and stops. Zero size requests and out-of-pool frees go straight from
// accept to the result stage. The result register lets the next request in
// while a response waits.
module bounce_slot_allocator import bsa_pkg::*; #(
	parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
	parameter int SLOT_SHIFT = SLOT_SHIFT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bsa_req_if.sink      req,
	bsa_rsp_if.source    rsp,
	bsa_cfg_if.sink      cfg
);

	localparam int IW = $clog2(NUM_SLOTS);
	localparam int EW = IW + 1;
	localparam int NW = SIZE_W + 1 - SLOT_SHIFT;
	localparam int SW = (NW > 8) ? NW : 8;
	localparam int AW = ((IW > SW) ? IW : SW) + 1;
	localparam logic [SIZE_W:0]   RND      = (SIZE_W + 1)'((1 << SLOT_SHIFT) - 1);
	localparam logic [EW-1:0]     NUM_E    = EW'(NUM_SLOTS);
	localparam logic [AW-1:0]     NUM_A    = AW'(NUM_SLOTS);
	localparam logic [ADDR_W-1:0] POOL_LEN = ADDR_W'(NUM_SLOTS) << SLOT_SHIFT;

	bsa_state_t state_q, state_d;

	logic [ADDR_W-1:0] pool_base_q;
	logic [2:0]        pss_q;
	logic [IW-1:0]     cursor_q;

	logic [EW-1:0]     fr_mem [NUM_SLOTS];
	logic [ADDR_W-1:0] og_mem [NUM_SLOTS];
	logic [EW-1:0]     fr_rdata_q;
	logic [ADDR_W-1:0] og_rdata_q;

	logic              fr_we, og_we;
	logic [IW-1:0]     fr_waddr, fr_raddr;
	logic [EW-1:0]     fr_wdata;

	logic              free_q;
	logic [NW-1:0]     n_q;
	logic [SW-1:0]     stride_q;
	logic [AW-1:0]     acc_q;
	logic [IW-1:0]     idx_q, start_q;
	logic              wrap_q;
	logic [EW-1:0]     ptr_q, lim_q, count_q;
	logic [ADDR_W-1:0] buf_q, bo_q, oa_q;
	bsa_status_t       sts_q;

	logic              rsp_valid_q;
	logic [1:0]        rsp_status_q;
	logic [ADDR_W-1:0] rsp_bo_q, rsp_oa_q;

	logic              acc_in, done_go;
	logic [SIZE_W:0]   size_sum;
	logic [NW-1:0]     n_in;
	logic [23:0]       page_bytes;
	logic [SW-1:0]     stride_in;
	logic [ADDR_W-1:0] off;
	logic              in_pool;
	logic              hit, fail;
	logic [AW-1:0]     nxt, sum_n;
	logic [EW-1:0]     lim_c, ptr_m1;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign acc_in    = req.valid && req.ready;
	assign done_go   = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	assign size_sum   = {1'b0, req.size_bytes} + RND;
	assign n_in       = size_sum[SIZE_W:SLOT_SHIFT];
	assign page_bytes = (24'd1 << SLOT_SHIFT) << pss_q;
	assign stride_in  = ({2'b00, req.size_bytes} > page_bytes) ?
		(SW'(1) << pss_q) : SW'(n_in);
	assign off        = req.bounce_addr_in - pool_base_q;
	assign in_pool    = off < POOL_LEN;

	assign hit    = AW'(fr_rdata_q) >= AW'(n_q);
	assign nxt    = AW'(idx_q) + AW'(stride_q);
	assign fail   = (nxt >= NUM_A) ? (start_q == '0) : (wrap_q && nxt >= AW'(start_q));
	assign sum_n  = AW'(idx_q) + AW'(n_q);
	assign lim_c  = (sum_n > NUM_A) ? NUM_E : EW'(sum_n);
	assign ptr_m1 = ptr_q - EW'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				if (ptr_q == NUM_E - EW'(1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (acc_in) begin
					if (n_in == '0) state_d = S_DONE;
					else if (req.action == ACT_ALLOC) state_d = S_A_RND;
					else if (in_pool) state_d = S_F_END;
					else state_d = S_DONE;
				end
			end
			S_A_RND: begin
				if (acc_q >= AW'(cursor_q)) state_d = S_A_RD;
			end
			S_A_RD: state_d = S_A_CMP;
			S_A_CMP: begin
				if (hit) state_d = S_A_ZERO;
				else if (fail) state_d = S_DONE;
				else state_d = S_A_RD;
			end
			S_A_ZERO: begin
				if (ptr_q + EW'(1) == lim_q) state_d = S_RN_RD;
			end
			S_F_END: state_d = S_F_CNT;
			S_F_CNT: state_d = S_F_FILL;
			S_F_FILL: begin
				if (ptr_m1 == EW'(idx_q)) state_d = S_RN_RD;
			end
			S_RN_RD: begin
				state_d = (ptr_q == '0) ? S_DONE : S_RN_CHK;
			end
			S_RN_CHK: begin
				state_d = (fr_rdata_q == '0) ? S_DONE : S_RN_RD;
			end
			S_DONE: begin
				if (done_go) state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end

	always_comb begin
		fr_we    = 1'b0;
		fr_waddr = ptr_q[IW-1:0];
		fr_wdata = '0;
		fr_raddr = idx_q;
		og_we    = 1'b0;
		case (state_q)
			S_INIT: begin
				fr_we    = 1'b1;
				fr_wdata = NUM_E - ptr_q;
			end
			S_A_CMP: og_we = hit;
			S_A_ZERO: fr_we = 1'b1;
			S_F_END: fr_raddr = lim_c[IW-1:0];
			S_F_FILL, S_RN_CHK: begin
				fr_we    = (state_q == S_F_FILL) || (fr_rdata_q != '0);
				fr_waddr = ptr_m1[IW-1:0];
				fr_wdata = count_q + EW'(1);
			end
			S_RN_RD: fr_raddr = ptr_m1[IW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fr_we) fr_mem[fr_waddr] <= fr_wdata;
		fr_rdata_q <= fr_mem[fr_raddr];
	end

	always_ff @(posedge clk) begin
		if (og_we) og_mem[idx_q] <= buf_q;
		og_rdata_q <= og_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			ptr_q       <= '0;
			cursor_q    <= '0;
			pool_base_q <= '0;
			pss_q       <= PAGE_SHIFT_RST;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				if (cfg.addr == REG_POOL_BASE) pool_base_q <= cfg.data;
				else pss_q <= cfg.data[2:0];
			end
			if (done_go) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				S_INIT: ptr_q <= ptr_q + EW'(1);
				S_A_CMP: if (hit) ptr_q <= EW'(idx_q);
				S_A_ZERO: begin
					if (ptr_q + EW'(1) == lim_q) begin
						ptr_q    <= EW'(idx_q);
						cursor_q <= (lim_q < NUM_E) ? lim_q[IW-1:0] : '0;
					end else begin
						ptr_q <= ptr_q + EW'(1);
					end
				end
				S_F_CNT: ptr_q <= lim_q;
				S_F_FILL: ptr_q <= ptr_m1;
				S_RN_CHK: if (fr_rdata_q != '0) ptr_q <= ptr_m1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				free_q   <= req.action;
				n_q      <= n_in;
				stride_q <= stride_in;
				buf_q    <= req.buffer_addr;
				idx_q    <= off[SLOT_SHIFT +: IW];
				acc_q    <= '0;
				bo_q     <= '0;
				oa_q     <= '0;
				sts_q    <= (n_in == '0) ? STS_ZERO : STS_OK;
			end
			S_A_RND: begin
				if (acc_q < AW'(cursor_q)) begin
					acc_q <= acc_q + AW'(stride_q);
				end else begin
					idx_q   <= (acc_q >= NUM_A) ? '0 : acc_q[IW-1:0];
					start_q <= (acc_q >= NUM_A) ? '0 : acc_q[IW-1:0];
					wrap_q  <= 1'b0;
				end
			end
			S_A_CMP: begin
				if (hit) begin
					lim_q   <= lim_c;
					count_q <= '0;
					bo_q    <= pool_base_q + (ADDR_W'(idx_q) << SLOT_SHIFT);
				end else if (fail) begin
					sts_q <= STS_NOSPACE;
				end else if (nxt >= NUM_A) begin
					idx_q  <= '0;
					wrap_q <= 1'b1;
				end else begin
					idx_q <= nxt[IW-1:0];
				end
			end
			S_F_END: lim_q <= lim_c;
			S_F_CNT: begin
				count_q <= (lim_q < NUM_E) ? fr_rdata_q : '0;
				oa_q    <= og_rdata_q;
			end
			S_F_FILL: count_q <= count_q + EW'(1);
			S_RN_CHK: if (fr_rdata_q != '0) count_q <= count_q + EW'(1);
			default: ;
		endcase
		if (done_go) begin
			rsp_status_q <= sts_q;
			rsp_bo_q     <= bo_q;
			rsp_oa_q     <= free_q ? oa_q : '0;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.bounce_addr_out = rsp_bo_q;
	assign rsp.orig_addr       = rsp_oa_q;

`ifndef ASSERT_OFF
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_INIT) |-> (EW'(cursor_q) < NUM_E))
		else $error("search cursor out of range");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_F_FILL || state_q == S_RN_CHK) |-> (count_q < NUM_E))
		else $error("run count overflow");
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("response without finished request");
	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_status_q != STS_OK) |-> (rsp_bo_q == '0 && rsp_oa_q == '0))
		else $error("failed request carries an address");
`endif

endmodule
